// ===== rtl/disk_request_scheduler_core_defines.svh =====
// Assertion macros shared by the disk request scheduler RTL.
`ifndef DISK_REQUEST_SCHEDULER_CORE_DEFINES_SVH
`define DISK_REQUEST_SCHEDULER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define DRS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Check that a condition on one edge is followed by a consequence on the next edge.
`define DRS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define DRS_ASSERT(lbl, prop, msg)
`define DRS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/drs_pkg.sv =====
// Constants, codes and types of the disk request scheduler.
package drs_pkg;

   localparam int DEPTH      = 32;
   localparam int TRACK_BITS = 16;
   localparam int TAG_BITS   = 10;
   localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int MODE_BITS  = 3;
   localparam int STATUS_BITS = 2;
   localparam int SUM_BITS   = 32;

   localparam logic [MODE_BITS-1:0] MODE_FIFO  = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_SSTF  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_LOOK  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_CLOOK = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_FLOOK = 3'd4;

   localparam logic ACTION_ADD   = 1'b0;
   localparam logic ACTION_ISSUE = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_ADDED  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ISSUED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH
   } state_type;

   // Kind of scan pass over the pending table.
   typedef enum logic [1:0] {
      PASS_ANY,   // look for any entry of the active bank
      PASS_DIR,   // nearest entry in a sweep direction
      PASS_ABS,   // nearest entry either way
      PASS_MIN    // lowest track
   } pass_type;

endpackage

// ===== rtl/drs_req_if.sv =====
// Request channel of the disk request scheduler.
interface drs_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [drs_pkg::TAG_BITS-1:0]   request_tag;
   logic [drs_pkg::TRACK_BITS-1:0] track;

   modport source (output valid, output action, output request_tag, output track,
                   input ready);
   modport sink   (input valid, input action, input request_tag, input track,
                   output ready);
endinterface

// ===== rtl/drs_rsp_if.sv =====
// Response channel of the disk request scheduler.
interface drs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [drs_pkg::STATUS_BITS-1:0]  status;
   logic [drs_pkg::TAG_BITS-1:0]     issued_tag;
   logic [drs_pkg::TRACK_BITS-1:0]   issued_track;
   logic [drs_pkg::TRACK_BITS-1:0]   seek_distance;
   logic [drs_pkg::SUM_BITS-1:0]     total_movement;

   modport source (output valid, output status, output issued_tag, output issued_track,
                   output seek_distance, output total_movement, input ready);
   modport sink   (input valid, input status, input issued_tag, input issued_track,
                   input seek_distance, input total_movement, output ready);
endinterface

// ===== rtl/disk_request_scheduler_core.sv =====
// Disk request scheduler: pending-request table with a sequenced scan unit.
// An add or an empty-table issue answers in the cycle after acceptance; any other issue runs
// P scan passes over the N pending entries, one entry per cycle through the single read
// port and subtractor (P = 0 FIFO, 1 SSTF, 1..2 LOOK and C-LOOK, 2..3 F-LOOK), then a fetch.
// Throughput: one transaction at a time; the next is taken once idle and the output is free.
// Reset (synchronous, active high) empties the table, parks the head at track 0, upward.
`include "disk_request_scheduler_core_defines.svh"

module disk_request_scheduler_core (
   input  logic                            clock,
   input  logic                            reset,
   drs_req_if.sink                         req,
   drs_rsp_if.source                       rsp,
   input  logic                            csr_write_en,
   input  logic [drs_pkg::MODE_BITS-1:0]   csr_write_data
);

   localparam int TB = drs_pkg::TRACK_BITS;
   localparam int GB = drs_pkg::TAG_BITS;
   localparam int IB = drs_pkg::IDX_BITS;
   localparam int CB = drs_pkg::CNT_BITS;
   localparam int SB = drs_pkg::SUM_BITS;

   // Pending table, kept in arrival order; no reset, only entries below the count are read.
   logic [GB-1:0] tag_ff   [drs_pkg::DEPTH];
   logic [TB-1:0] track_ff [drs_pkg::DEPTH];
   logic          bank_ff  [drs_pkg::DEPTH];

   // Sequencer state
   drs_pkg::state_type state_ff, state_in;
   drs_pkg::pass_type  pass_ff, pass_in;
   logic [IB-1:0]      scan_idx_ff, scan_idx_in;
   logic               found_ff, found_in;
   logic [IB-1:0]      best_idx_ff, best_idx_in;
   logic [TB-1:0]      best_d_ff, best_d_in;
   logic               second_ff, second_in;
   logic [IB-1:0]      pick_ff, pick_in;

   // Architectural state
   logic [CB-1:0]                   count_ff, count_in;
   logic [TB-1:0]                   head_ff, head_in;
   logic                            sweep_ff, sweep_in;     // 0 upward, 1 downward
   logic                            active_ff, active_in;   // active F-LOOK bank
   logic [SB-1:0]                   sum_ff, sum_in;
   logic [drs_pkg::MODE_BITS-1:0]   mode_ff, mode_in;

   // Output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [drs_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [GB-1:0]                   rsp_tag_ff, rsp_tag_in;
   logic [TB-1:0]                   rsp_track_ff, rsp_track_in;
   logic [TB-1:0]                   rsp_dist_ff, rsp_dist_in;
   logic [SB-1:0]                   rsp_total_ff, rsp_total_in;

   logic req_accept;
   logic out_free;
   logic add_we;
   logic shift_en;

   // Shared read port and distance unit
   logic [IB-1:0] rd_idx;
   logic [TB-1:0] rd_track;
   logic [GB-1:0] rd_tag;
   logic          rd_bank;
   logic [TB:0]   sub_full;
   logic          borrow;
   logic [TB-1:0] diff;
   logic [TB-1:0] ndiff;
   logic [TB-1:0] abs_d;
   logic          at_or_below;

   // Per-entry scan decision
   logic          scan_dir;
   logic          use_bank;
   logic          qualify;
   logic [TB-1:0] cand_d;
   logic          update;
   logic          last;
   logic          found_fin;
   logic [IB-1:0] best_fin;
   logic          scan_pass;
   logic [SB:0]   sum_wide;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign req.ready  = (state_ff == drs_pkg::ST_IDLE) && out_free;
   assign req_accept = req.valid && req.ready;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.issued_tag     = rsp_tag_ff;
   assign rsp.issued_track   = rsp_track_ff;
   assign rsp.seek_distance  = rsp_dist_ff;
   assign rsp.total_movement = rsp_total_ff;

   assign mode_in = csr_write_en ? csr_write_data : mode_ff;

   // The scan walks the table; the fetch reads the chosen entry through the same port.
   assign rd_idx   = (state_ff == drs_pkg::ST_FETCH) ? pick_ff : scan_idx_ff;
   assign rd_track = track_ff[rd_idx];
   assign rd_tag   = tag_ff[rd_idx];
   assign rd_bank  = bank_ff[rd_idx];

   // One subtractor gives the signed offset of the entry from the head.
   assign sub_full    = {1'b0, rd_track} - {1'b0, head_ff};
   assign borrow      = sub_full[TB];
   assign diff        = sub_full[TB-1:0];
   assign ndiff       = '0 - diff;
   assign abs_d       = borrow ? ndiff : diff;
   assign at_or_below = borrow || (diff == '0);

   // C-LOOK always sweeps upward; only F-LOOK filters by bank.
   assign scan_dir = (mode_ff == drs_pkg::MODE_CLOOK) ? 1'b0 : sweep_ff;
   assign use_bank = (mode_ff == drs_pkg::MODE_FLOOK);

   always_comb begin
      qualify = 1'b0;
      cand_d  = abs_d;
      case (pass_ff)
         drs_pkg::PASS_ANY: begin
            qualify = (rd_bank == active_ff);
         end
         drs_pkg::PASS_DIR: begin
            qualify = (!use_bank || (rd_bank == active_ff)) &&
                      (scan_dir ? at_or_below : !borrow);
            cand_d  = scan_dir ? ndiff : diff;
         end
         drs_pkg::PASS_ABS: begin
            qualify = 1'b1;
         end
         drs_pkg::PASS_MIN: begin
            qualify = 1'b1;
            cand_d  = rd_track;
         end
         default: begin
            qualify = 1'b0;
         end
      endcase
   end

   // Strict compare keeps the oldest entry on ties.
   assign update    = qualify && (!found_ff || (cand_d < best_d_ff));
   assign last      = ((CB'(scan_idx_ff) + CB'(1)) == count_ff);
   assign found_fin = found_ff || update;
   assign best_fin  = update ? scan_idx_ff : best_idx_ff;

   // An issue on a non-empty table scans unless the mode takes the oldest entry.
   always_comb begin
      unique case (mode_ff) inside
         drs_pkg::MODE_SSTF, drs_pkg::MODE_LOOK,
         drs_pkg::MODE_CLOOK, drs_pkg::MODE_FLOOK: scan_pass = 1'b1;
         default:                                   scan_pass = 1'b0;
      endcase
   end

   assign sum_wide = {1'b0, sum_ff} + (SB + 1)'(abs_d);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         drs_pkg::ST_IDLE: begin
            if (req_accept && (req.action == drs_pkg::ACTION_ISSUE) && (count_ff != '0)) begin
               state_in = scan_pass ? drs_pkg::ST_SCAN : drs_pkg::ST_FETCH;
            end
         end
         drs_pkg::ST_SCAN: begin
            if (last) begin
               case (pass_ff) inside
                  drs_pkg::PASS_ABS, drs_pkg::PASS_MIN: state_in = drs_pkg::ST_FETCH;
                  drs_pkg::PASS_DIR: begin
                     if (found_fin || (second_ff && (mode_ff != drs_pkg::MODE_CLOOK))) begin
                        state_in = drs_pkg::ST_FETCH;
                     end
                  end
                  default: state_in = drs_pkg::ST_SCAN;
               endcase
            end
         end
         drs_pkg::ST_FETCH: begin
            if (out_free) begin
               state_in = drs_pkg::ST_IDLE;
            end
         end
         default: state_in = drs_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      pass_in       = pass_ff;
      scan_idx_in   = scan_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_d_in     = best_d_ff;
      second_in     = second_ff;
      pick_in       = pick_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      sweep_in      = sweep_ff;
      active_in     = active_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_track_in  = rsp_track_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_total_in  = rsp_total_ff;
      add_we        = 1'b0;
      shift_en      = 1'b0;

      unique case (state_ff)
         drs_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req.action == drs_pkg::ACTION_ADD || count_ff == '0) begin
                  // Answer at once: add, full table or nothing pending.
                  rsp_valid_in = 1'b1;
                  rsp_tag_in   = '0;
                  rsp_track_in = '0;
                  rsp_dist_in  = '0;
                  rsp_total_in = sum_ff;
                  if (req.action == drs_pkg::ACTION_ISSUE) begin
                     rsp_status_in = drs_pkg::STATUS_EMPTY;
                  end else if (count_ff == CB'(drs_pkg::DEPTH)) begin
                     rsp_status_in = drs_pkg::STATUS_FULL;
                  end else begin
                     rsp_status_in = drs_pkg::STATUS_ADDED;
                     add_we        = 1'b1;
                     count_in      = count_ff + CB'(1);
                  end
               end else begin
                  // Arm the first scan pass, or the fetch of the oldest entry in FIFO mode.
                  scan_idx_in = '0;
                  found_in    = 1'b0;
                  second_in   = 1'b0;
                  pick_in     = '0;
                  case (mode_ff)
                     drs_pkg::MODE_SSTF:  pass_in = drs_pkg::PASS_ABS;
                     drs_pkg::MODE_FLOOK: pass_in = drs_pkg::PASS_ANY;
                     default:             pass_in = drs_pkg::PASS_DIR;
                  endcase
               end
            end
         end
         drs_pkg::ST_SCAN: begin
            scan_idx_in = scan_idx_ff + IB'(1);
            if (update) begin
               found_in    = 1'b1;
               best_idx_in = scan_idx_ff;
               best_d_in   = cand_d;
            end
            if (last) begin
               scan_idx_in = '0;
               found_in    = 1'b0;
               case (pass_ff)
                  drs_pkg::PASS_ANY: begin
                     // Swap banks when the active one holds nothing.
                     if (!found_fin) begin
                        active_in = !active_ff;
                     end
                     pass_in = drs_pkg::PASS_DIR;
                  end
                  drs_pkg::PASS_DIR: begin
                     if (found_fin) begin
                        pick_in = best_fin;
                     end else if (mode_ff == drs_pkg::MODE_CLOOK) begin
                        pass_in = drs_pkg::PASS_MIN;
                     end else if (!second_ff) begin
                        // Nothing ahead: reverse and look again.
                        sweep_in  = !sweep_ff;
                        second_in = 1'b1;
                     end else begin
                        pick_in = '0;
                     end
                  end
                  default: begin
                     pick_in = best_fin;
                  end
               endcase
            end
         end
         drs_pkg::ST_FETCH: begin
            if (out_free) begin
               // Issue the chosen entry, move the head, close the gap.
               shift_en      = 1'b1;
               count_in      = count_ff - CB'(1);
               head_in       = rd_track;
               sum_in        = sum_wide[SB] ? '1 : sum_wide[SB-1:0];
               rsp_valid_in  = 1'b1;
               rsp_status_in = drs_pkg::STATUS_ISSUED;
               rsp_tag_in    = rd_tag;
               rsp_track_in  = rd_track;
               rsp_dist_in   = abs_d;
               rsp_total_in  = sum_wide[SB] ? '1 : sum_wide[SB-1:0];
            end
         end
         default: begin
            add_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drs_pkg::ST_IDLE;
         pass_ff      <= drs_pkg::PASS_ANY;
         scan_idx_ff  <= '0;
         found_ff     <= 1'b0;
         second_ff    <= 1'b0;
         pick_ff      <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         sweep_ff     <= 1'b0;
         active_ff    <= 1'b0;
         sum_ff       <= '0;
         mode_ff      <= drs_pkg::MODE_FIFO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         scan_idx_ff  <= scan_idx_in;
         found_ff     <= found_in;
         second_ff    <= second_in;
         pick_ff      <= pick_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         sweep_ff     <= sweep_in;
         active_ff    <= active_in;
         sum_ff       <= sum_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_d_ff     <= best_d_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_track_ff  <= rsp_track_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // Table: append at the count, drop the issued entry by shifting the younger ones down.
   always_ff @(posedge clock) begin
      for (int i = 0; i < drs_pkg::DEPTH - 1; i++) begin
         if (shift_en && (IB'(i) >= pick_ff)) begin
            tag_ff[i]   <= tag_ff[i + 1];
            track_ff[i] <= track_ff[i + 1];
            bank_ff[i]  <= bank_ff[i + 1];
         end
      end
      if (add_we) begin
         tag_ff[count_ff[IB-1:0]]   <= req.request_tag;
         track_ff[count_ff[IB-1:0]] <= req.track;
         bank_ff[count_ff[IB-1:0]]  <= !active_ff;
      end
   end

   `DRS_ASSERT(a_count_bound, count_ff <= CB'(drs_pkg::DEPTH), "entry count beyond depth")
   `DRS_ASSERT(a_pick_valid,
      (state_ff != drs_pkg::ST_FETCH) || (CB'(pick_ff) < count_ff),
      "pick outside pending entries")
   `DRS_ASSERT_NEXT(a_issue_pops, (state_ff == drs_pkg::ST_FETCH) && out_free,
      count_ff == $past(count_ff) - CB'(1), "issue did not remove an entry")
   `DRS_ASSERT_NEXT(a_bank_flook, mode_ff != drs_pkg::MODE_FLOOK,
      active_ff == $past(active_ff), "bank moved outside F-LOOK")
   `DRS_ASSERT_NEXT(a_sum_grows, 1'b1, sum_ff >= $past(sum_ff), "movement total decreased")

endmodule
